// ----- hdl/pmc_pkg.sv -----
// ----------------------------------------------------------------------------
// pmc_pkg
// shared types, codes and constants of the pointer motion coalescer
// ----------------------------------------------------------------------------
package pmc_pkg;

    localparam int TIME_BITS  = 40;
    localparam int WIN_W      = 20;
    localparam int QDEPTH     = 2;
    localparam int QPTR_W     = $clog2(QDEPTH);
    localparam int QCNT_W     = $clog2(QDEPTH + 1);

    localparam logic [WIN_W-1:0] WIN_RESET = WIN_W'(10000);

    localparam logic       FUNC_EVENT  = 1'b0;
    localparam logic       FUNC_FLUSH  = 1'b1;
    localparam logic       KIND_MOTION = 1'b0;
    localparam logic       KIND_OTHER  = 1'b1;
    localparam logic [1:0] AXIS_X      = 2'd0;
    localparam logic [1:0] AXIS_Y      = 2'd1;

    typedef struct packed {
        logic                 func;
        logic [7:0]           src_dev;
        logic                 kind;
        logic [1:0]           axis;
        logic                 is_absolute;
        logic signed [31:0]   abs_value;
        logic signed [31:0]   rel_value;
        logic [TIME_BITS-1:0] timestamp_us;
        logic                 sink_active;
    } pmc_in_t;

    typedef struct packed {
        logic [7:0]         device_id_res;
        logic               kind_res;
        logic [1:0]         axis_res;
        logic               is_absolute_res;
        logic signed [31:0] abs_value_res;
        logic signed [31:0] rel_value_res;
        logic               follow;
        logic               last;
    } pmc_out_t;

    // one pending motion record
    typedef struct packed {
        logic [7:0]         dev;
        logic               absolute;
        logic signed [31:0] absval;
        logic signed [31:0] relval;
    } pmc_rec_t;

    // pass-through event
    typedef struct packed {
        logic [7:0]         dev;
        logic               kind;
        logic [1:0]         axis;
        logic               absolute;
        logic signed [31:0] absval;
        logic signed [31:0] relval;
    } pmc_pass_t;

    // everything one input transaction delivers
    typedef struct packed {
        logic      x_v;
        logic      y_v;
        logic      p_v;
        pmc_rec_t  x_rec;
        pmc_rec_t  y_rec;
        pmc_pass_t pass;
    } pmc_job_t;

    typedef struct packed {
        logic              full;
        logic              head_valid;
    } pmc_q_stat_t;

    function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                   input logic signed [31:0] b);
        logic [32:0] s;
        s = {a[31], a} + {b[31], b};
        if (s[32] != s[31])
            sat_add = s[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
        else
            sat_add = s[31:0];
    endfunction

endpackage

// ----- hdl/pmc_front.sv -----
// ----------------------------------------------------------------------------
// pmc_front
// accepts events, keeps the pending axis records and the window, issues jobs
// ----------------------------------------------------------------------------
module pmc_front (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      ev_valid,
    output logic                      ev_ready,
    input  pmc_pkg::pmc_in_t          ev_data,
    input  logic                      cfg_we,
    input  logic [pmc_pkg::WIN_W-1:0] cfg_wdata,
    input  pmc_pkg::pmc_q_stat_t      q_stat,
    output logic                      push,
    output pmc_pkg::pmc_job_t         job
);

    logic [pmc_pkg::WIN_W-1:0]     win_reg;
    logic                          xp_reg, xp_next;
    logic                          yp_reg, yp_next;
    pmc_pkg::pmc_rec_t             xr_reg, xr_next;
    pmc_pkg::pmc_rec_t             yr_reg, yr_next;
    logic                          ws_reg, ws_next;
    logic [pmc_pkg::TIME_BITS-1:0] wst_reg, wst_next;

    logic                          accept;
    logic                          is_motion;
    logic                          stale;
    logic                          do_flush;
    logic                          xp_after, yp_after;
    logic [pmc_pkg::TIME_BITS-1:0] elapsed;
    logic signed [31:0]            x_sum, y_sum;
    pmc_pkg::pmc_rec_t             new_rec;

    assign ev_ready  = !q_stat.full;
    assign accept    = ev_valid && ev_ready;
    assign is_motion = (ev_data.kind == pmc_pkg::KIND_MOTION) &&
                       (ev_data.axis == pmc_pkg::AXIS_X || ev_data.axis == pmc_pkg::AXIS_Y);
    assign elapsed   = ev_data.timestamp_us - wst_reg;
    assign x_sum     = pmc_pkg::sat_add(ev_data.rel_value, xr_reg.relval);
    assign y_sum     = pmc_pkg::sat_add(ev_data.rel_value, yr_reg.relval);

    always_comb
    begin
        stale = (xp_reg && xr_reg.dev != ev_data.src_dev) ||
                (yp_reg && yr_reg.dev != ev_data.src_dev) ||
                (ws_reg && elapsed > pmc_pkg::TIME_BITS'(win_reg));

        if (ev_data.func == pmc_pkg::FUNC_FLUSH)
            do_flush = 1'b1;
        else if (is_motion)
            do_flush = stale;
        else
            do_flush = 1'b1;

        xp_after = xp_reg && !do_flush;
        yp_after = yp_reg && !do_flush;

        job.x_v   = do_flush && xp_reg && ev_data.sink_active;
        job.y_v   = do_flush && yp_reg && ev_data.sink_active;
        job.p_v   = (ev_data.func == pmc_pkg::FUNC_EVENT) && !is_motion &&
                    ev_data.sink_active;
        job.x_rec = xr_reg;
        job.y_rec = yr_reg;
        job.pass  = '{dev: ev_data.src_dev, kind: ev_data.kind, axis: ev_data.axis,
                      absolute: ev_data.is_absolute, absval: ev_data.abs_value,
                      relval: ev_data.rel_value};
        push      = accept && (job.x_v || job.y_v || job.p_v);

        // merged record for the axis of a motion event
        new_rec.dev      = ev_data.src_dev;
        new_rec.absolute = ev_data.is_absolute;
        new_rec.absval   = ev_data.abs_value;
        new_rec.relval   = ev_data.rel_value;

        xp_next  = xp_reg;
        yp_next  = yp_reg;
        xr_next  = xr_reg;
        yr_next  = yr_reg;
        ws_next  = ws_reg;
        wst_next = wst_reg;

        if (accept)
        begin
            xp_next = xp_after;
            yp_next = yp_after;
            if (do_flush)
            begin
                ws_next  = 1'b0;
                wst_next = '0;
            end
            if (ev_data.func == pmc_pkg::FUNC_EVENT && is_motion)
            begin
                if (!ws_reg || do_flush)
                begin
                    ws_next  = 1'b1;
                    wst_next = ev_data.timestamp_us;
                end
                if (ev_data.axis == pmc_pkg::AXIS_X)
                begin
                    xr_next = new_rec;
                    if (!ev_data.is_absolute && xp_after)
                        xr_next.relval = x_sum;
                    xp_next = 1'b1;
                end
                else
                begin
                    yr_next = new_rec;
                    if (!ev_data.is_absolute && yp_after)
                        yr_next.relval = y_sum;
                    yp_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg <= pmc_pkg::WIN_RESET;
            xp_reg  <= 1'b0;
            yp_reg  <= 1'b0;
            ws_reg  <= 1'b0;
            wst_reg <= '0;
        end
        else
        begin
            if (cfg_we)
                win_reg <= cfg_wdata;
            xp_reg  <= xp_next;
            yp_reg  <= yp_next;
            ws_reg  <= ws_next;
            wst_reg <= wst_next;
        end
    end

    // record payload, meaningful only while pending
    always_ff @(posedge clk)
    begin
        xr_reg <= xr_next;
        yr_reg <= yr_next;
    end

endmodule

// ----- hdl/pmc_queue.sv -----
// ----------------------------------------------------------------------------
// pmc_queue
// short job queue between front and back
// ----------------------------------------------------------------------------
module pmc_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  pmc_pkg::pmc_job_t    push_job,
    input  logic                 pop,
    output pmc_pkg::pmc_job_t    head_job,
    output pmc_pkg::pmc_q_stat_t stat
);

    pmc_pkg::pmc_job_t                mem_reg [pmc_pkg::QDEPTH];
    logic [pmc_pkg::QPTR_W-1:0]       wp_reg, wp_next;
    logic [pmc_pkg::QPTR_W-1:0]       rp_reg, rp_next;
    logic [pmc_pkg::QCNT_W-1:0]       cnt_reg, cnt_next;
    logic                             do_push, do_pop;

    assign do_push         = push && (cnt_reg != pmc_pkg::QCNT_W'(pmc_pkg::QDEPTH));
    assign do_pop          = pop && (cnt_reg != '0);
    assign head_job        = mem_reg[rp_reg];
    assign stat.full       = (cnt_reg == pmc_pkg::QCNT_W'(pmc_pkg::QDEPTH));
    assign stat.head_valid = (cnt_reg != '0);

    always_comb
    begin
        wp_next  = wp_reg;
        rp_next  = rp_reg;
        cnt_next = cnt_reg;
        if (do_push)
            wp_next = (wp_reg == pmc_pkg::QPTR_W'(pmc_pkg::QDEPTH - 1)) ? '0 : wp_reg + 1'b1;
        if (do_pop)
            rp_next = (rp_reg == pmc_pkg::QPTR_W'(pmc_pkg::QDEPTH - 1)) ? '0 : rp_reg + 1'b1;
        if (do_push && !do_pop)
            cnt_next = cnt_reg + 1'b1;
        else if (do_pop && !do_push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wp_reg] <= push_job;
    end

endmodule

// ----- hdl/pmc_back.sv -----
// ----------------------------------------------------------------------------
// pmc_back
// walks the head job and delivers its events through the output register
// ----------------------------------------------------------------------------
module pmc_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  pmc_pkg::pmc_job_t    head_job,
    input  pmc_pkg::pmc_q_stat_t q_stat,
    output logic                 pop,
    output logic                 res_valid,
    input  logic                 res_ready,
    output pmc_pkg::pmc_out_t    res_data
);

    logic [2:0]        done_reg, done_next;
    logic              ov_reg, ov_next;
    pmc_pkg::pmc_out_t od_reg, od_next;
    logic [2:0]        rem;
    logic [2:0]        sel;
    logic              load;

    assign rem  = {head_job.p_v, head_job.y_v, head_job.x_v} & ~done_reg;
    assign load = q_stat.head_valid && (!ov_reg || res_ready);

    always_comb
    begin
        // x first, then y, then the passing event
        if (rem[0])
            sel = 3'b001;
        else if (rem[1])
            sel = 3'b010;
        else
            sel = 3'b100;

        od_next = od_reg;
        case (sel)
            3'b001:
            begin
                od_next.device_id_res   = head_job.x_rec.dev;
                od_next.kind_res        = pmc_pkg::KIND_MOTION;
                od_next.axis_res        = pmc_pkg::AXIS_X;
                od_next.is_absolute_res = head_job.x_rec.absolute;
                od_next.abs_value_res   = head_job.x_rec.absval;
                od_next.rel_value_res   = head_job.x_rec.relval;
                od_next.follow          = head_job.y_v;
            end
            3'b010:
            begin
                od_next.device_id_res   = head_job.y_rec.dev;
                od_next.kind_res        = pmc_pkg::KIND_MOTION;
                od_next.axis_res        = pmc_pkg::AXIS_Y;
                od_next.is_absolute_res = head_job.y_rec.absolute;
                od_next.abs_value_res   = head_job.y_rec.absval;
                od_next.rel_value_res   = head_job.y_rec.relval;
                od_next.follow          = 1'b0;
            end
            default:
            begin
                od_next.device_id_res   = head_job.pass.dev;
                od_next.kind_res        = head_job.pass.kind;
                od_next.axis_res        = head_job.pass.axis;
                od_next.is_absolute_res = head_job.pass.absolute;
                od_next.abs_value_res   = head_job.pass.absval;
                od_next.rel_value_res   = head_job.pass.relval;
                od_next.follow          = 1'b0;
            end
        endcase
        od_next.last = ((rem & ~sel) == 3'b000);

        pop       = load && od_next.last;
        done_next = done_reg;
        ov_next   = ov_reg;
        if (load)
        begin
            ov_next   = 1'b1;
            done_next = od_next.last ? 3'b000 : (done_reg | sel);
        end
        else if (res_ready)
            ov_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 3'b000;
            ov_reg   <= 1'b0;
        end
        else
        begin
            done_reg <= done_next;
            ov_reg   <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            od_reg <= od_next;
    end

    assign res_valid = ov_reg;
    assign res_data  = od_reg;

endmodule

// ----- hdl/pointer_motion_coalescer.sv -----
// ----------------------------------------------------------------------------
// pointer_motion_coalescer
// merges X/Y pointer motion and flushes it ahead of other traffic
// ----------------------------------------------------------------------------
// path: each job is written into the job queue, then loaded into the output register
// throughput: one input transaction per cycle while the job queue has room;
//   one result per cycle at the output while the receiver is ready, with the
//   single output register draining each job one event at a time
// reset: pending marks, window and queue clear at once; window register 10000
// ----------------------------------------------------------------------------
module pointer_motion_coalescer (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      ev_valid,
    output logic                      ev_ready,
    input  pmc_pkg::pmc_in_t          ev_data,
    output logic                      res_valid,
    input  logic                      res_ready,
    output pmc_pkg::pmc_out_t         res_data,
    input  logic                      cfg_we,
    input  logic [pmc_pkg::WIN_W-1:0] cfg_wdata
);

    // front to queue
    logic                 push;
    pmc_pkg::pmc_job_t    push_job;
    // queue to back
    logic                 pop;
    pmc_pkg::pmc_job_t    head_job;
    pmc_pkg::pmc_q_stat_t q_stat;

    // front: classifies each transaction, updates pending records, issues a job
    pmc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .ev_valid  (ev_valid),
        .ev_ready  (ev_ready),
        .ev_data   (ev_data),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .q_stat    (q_stat),
        .push      (push),
        .job       (push_job)
    );

    // two-deep job queue lets the front run on while results wait
    pmc_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head_job (head_job),
        .stat     (q_stat)
    );

    // back: delivers x, y and passing event of a job in turn
    pmc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head_job  (head_job),
        .q_stat    (q_stat),
        .pop       (pop),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_data  (res_data)
    );

    // follow mark only on an x event that is not the last of its transaction
    a_follow_x : assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_data.follow |->
            res_data.axis_res == pmc_pkg::AXIS_X && !res_data.last)
        else $error("follow mark on wrong event");

    // the y event comes right after a followed x event
    a_follow_y : assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_ready && res_data.follow |=>
            res_valid && res_data.axis_res == pmc_pkg::AXIS_Y)
        else $error("y event did not follow");

    // a passing non-motion event always closes its transaction
    a_pass_last : assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_data.kind_res == pmc_pkg::KIND_OTHER |-> res_data.last)
        else $error("passing event not last");

endmodule

// ----- tb/sv/pointer_motion_coalescer_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pointer_motion_coalescer_test
// self-checking bench: a directed table then random traffic over several
// window settings, every delivered event checked against the table or a local predictor
// ----------------------------------------------------------------------------
module pointer_motion_coalescer_test;

    // codes the package leaves out
    localparam logic [1:0]  AXIS_OTHER = 2'd2;
    localparam logic [1:0]  AXIS_SPARE = 2'd3;
    localparam logic        ABS        = 1'b1;
    localparam logic        REL        = 1'b0;
    localparam logic        SINK_ON    = 1'b1;
    localparam logic        SINK_OFF   = 1'b0;
    localparam logic [31:0] S32_MAX    = 32'h7fff_ffff;
    localparam logic [31:0] S32_MIN    = 32'h8000_0000;

    localparam int IDLE_MAX    = 17;
    localparam int SETTLE      = 8;     // quiet cycles before a window write
    localparam int LONG_HOLD   = 120;   // receiver hold-off under pressure
    localparam int QUIET_LIMIT = 4000;  // watchdog: cycles with no transaction
    localparam int PHASE_ITEMS = 39;

    // one row of the directed table; fixed rows carry their deliveries
    typedef struct packed {
        pmc_pkg::pmc_in_t         item;
        logic                     fixed;
        logic [1:0]               n_fixed;
        pmc_pkg::pmc_out_t [2:0]  outs;
    } plan_row_t;

    logic                         clk = 1'b0;
    logic                         rst_n = 1'b0;
    logic                         ev_valid = 1'b0;
    logic                         ev_ready;
    pmc_pkg::pmc_in_t             ev_data = '0;
    logic                         res_valid;
    logic                         res_ready = 1'b0;
    pmc_pkg::pmc_out_t            res_data;
    logic                         cfg_we = 1'b0;
    logic [pmc_pkg::WIN_W-1:0]    cfg_wdata = '0;

    // predictor state, mirrors the block
    logic                         m_x_pend = 1'b0;
    logic                         m_y_pend = 1'b0;
    pmc_pkg::pmc_rec_t            m_x = '0;
    pmc_pkg::pmc_rec_t            m_y = '0;
    logic                         m_win_on = 1'b0;
    logic [pmc_pkg::TIME_BITS-1:0] m_win_t = '0;
    logic [pmc_pkg::WIN_W-1:0]    m_window = pmc_pkg::WIN_RESET;

    // deliveries still owed by the block, oldest first
    pmc_pkg::pmc_out_t            due_q[$];
    plan_row_t                    plan[$];

    // what the sender is offering right now
    logic                         cur_fixed = 1'b0;
    logic [1:0]                   cur_n = '0;
    pmc_pkg::pmc_out_t [2:0]      cur_outs = '0;

    logic                         idle_on = 1'b1;
    logic                         long_hold_req = 1'b0;
    int                           errors = 0;

    // random traffic context
    logic [pmc_pkg::TIME_BITS-1:0] ts_now = '0;
    logic [7:0]                   cur_dev = '0;

    pointer_motion_coalescer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .ev_valid  (ev_valid),
        .ev_ready  (ev_ready),
        .ev_data   (ev_data),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_data  (res_data),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // 12 ns period
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------

    function automatic logic signed [31:0] clamp_sum(input logic signed [31:0] a,
                                                     input logic signed [31:0] b);
        longint s;
        s = longint'(a) + longint'(b);
        if (s > 64'sd2147483647)
            return S32_MAX;
        if (s < -64'sd2147483648)
            return S32_MIN;
        return s[31:0];
    endfunction

    function automatic pmc_pkg::pmc_out_t mk_out(input logic [7:0] dev, input logic kind,
                                                 input logic [1:0] axis, input logic absf,
                                                 input logic [31:0] absval,
                                                 input logic [31:0] relval,
                                                 input logic follow, input logic last);
        pmc_pkg::pmc_out_t o;
        o.device_id_res   = dev;
        o.kind_res        = kind;
        o.axis_res        = axis;
        o.is_absolute_res = absf;
        o.abs_value_res   = absval;
        o.rel_value_res   = relval;
        o.follow          = follow;
        o.last            = last;
        return o;
    endfunction

    // relative adds onto whatever is pending, absolute replaces it
    function automatic pmc_pkg::pmc_rec_t merge_motion(input pmc_pkg::pmc_rec_t old,
                                                       input logic pend,
                                                       input pmc_pkg::pmc_in_t it);
        pmc_pkg::pmc_rec_t r;
        logic signed [31:0] prior;
        prior = (!it.is_absolute && pend) ? old.relval : 32'sd0;
        r.dev      = it.src_dev;
        r.absolute = it.is_absolute;
        r.absval   = it.abs_value;
        r.relval   = it.is_absolute ? it.rel_value : clamp_sum(it.rel_value, prior);
        return r;
    endfunction

    // X goes out first, follow set when Y comes after it; dropped when inactive
    task automatic flush_model(input logic active, inout pmc_pkg::pmc_out_t [2:0] res,
                               inout int n);
        if (!m_x_pend && !m_y_pend)
            return;
        if (active)
        begin
            if (m_x_pend)
            begin
                res[n] = mk_out(m_x.dev, pmc_pkg::KIND_MOTION, pmc_pkg::AXIS_X,
                                m_x.absolute, m_x.absval, m_x.relval, m_y_pend, 1'b0);
                n++;
            end
            if (m_y_pend)
            begin
                res[n] = mk_out(m_y.dev, pmc_pkg::KIND_MOTION, pmc_pkg::AXIS_Y,
                                m_y.absolute, m_y.absval, m_y.relval, 1'b0, 1'b0);
                n++;
            end
        end
        m_x_pend = 1'b0;
        m_y_pend = 1'b0;
        m_win_on = 1'b0;
        m_win_t  = '0;
    endtask

    task automatic coalesce_predict(input pmc_pkg::pmc_in_t it,
                                    output pmc_pkg::pmc_out_t [2:0] res,
                                    output int n);
        logic                          stale;
        logic [pmc_pkg::TIME_BITS-1:0] elapsed;
        res = '0;
        n   = 0;
        if (it.func == pmc_pkg::FUNC_FLUSH)
        begin
            flush_model(it.sink_active, res, n);
        end
        else if (it.kind == pmc_pkg::KIND_MOTION &&
                 (it.axis == pmc_pkg::AXIS_X || it.axis == pmc_pkg::AXIS_Y))
        begin
            stale = (m_x_pend && m_x.dev != it.src_dev) ||
                    (m_y_pend && m_y.dev != it.src_dev);
            // elapsed time wraps, so a step backwards looks huge
            elapsed = it.timestamp_us - m_win_t;
            if (m_win_on && elapsed > pmc_pkg::TIME_BITS'(m_window))
                stale = 1'b1;
            if (stale)
                flush_model(it.sink_active, res, n);
            if (!m_win_on)
            begin
                m_win_on = 1'b1;
                m_win_t  = it.timestamp_us;
            end
            if (it.axis == pmc_pkg::AXIS_X)
            begin
                m_x      = merge_motion(m_x, m_x_pend, it);
                m_x_pend = 1'b1;
            end
            else
            begin
                m_y      = merge_motion(m_y, m_y_pend, it);
                m_y_pend = 1'b1;
            end
        end
        else
        begin
            // anything else passes through behind the flush
            flush_model(it.sink_active, res, n);
            if (it.sink_active)
            begin
                res[n] = mk_out(it.src_dev, it.kind, it.axis, it.is_absolute,
                                it.abs_value, it.rel_value, 1'b0, 1'b0);
                n++;
            end
        end
        if (n > 0)
            res[n-1].last = 1'b1;
    endtask

    // ------------------------------------------------------------------
    // scoreboard: predict on input transactions, check output transactions
    // ------------------------------------------------------------------

    task automatic check_field(input string fname, input longint want_v,
                               input longint got_v);
        if (want_v != got_v)
        begin
            $display("%0t ns: %s mismatch, expected %0d actual %0d",
                     $time, fname, want_v, got_v);
            errors++;
        end
    endtask

    always @(posedge clk)
    begin : score
        pmc_pkg::pmc_out_t [2:0] predicted;
        int                      n_pred;
        pmc_pkg::pmc_out_t       want;
        if (rst_n)
        begin
            if (ev_valid && ev_ready)
            begin
                coalesce_predict(ev_data, predicted, n_pred);
                // fixed rows keep the predictor in step but use their own values
                if (cur_fixed)
                begin
                    predicted = cur_outs;
                    n_pred    = cur_n;
                end
                for (int i = 0; i < n_pred; i++)
                    due_q.push_back(predicted[i]);
            end
            if (res_valid && res_ready)
            begin
                if (due_q.size() == 0)
                begin
                    $display("%0t ns: unexpected result, expected none actual %p",
                             $time, res_data);
                    errors++;
                end
                else
                begin
                    want = due_q.pop_front();
                    check_field("device_id_res", want.device_id_res,
                                res_data.device_id_res);
                    check_field("kind_res", want.kind_res, res_data.kind_res);
                    check_field("axis_res", want.axis_res, res_data.axis_res);
                    check_field("is_absolute_res", want.is_absolute_res,
                                res_data.is_absolute_res);
                    check_field("abs_value_res", want.abs_value_res,
                                res_data.abs_value_res);
                    check_field("rel_value_res", want.rel_value_res,
                                res_data.rel_value_res);
                    check_field("follow", want.follow, res_data.follow);
                    check_field("last", want.last, res_data.last);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // receiver: random stall after each output transaction while idling is on, plus one long
    // hold-off on request so the job queue backs up into the input
    // ------------------------------------------------------------------

    initial
    begin : sink_side
        logic took;
        int   wait_left;
        wait_left = 0;
        forever
        begin
            @(posedge clk);
            took = res_valid && res_ready;
            @(negedge clk);
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                res_ready <= 1'b0;
                repeat (LONG_HOLD) @(negedge clk);
            end
            if (took)
                wait_left = idle_on ? $urandom_range(0, IDLE_MAX) : 0;
            if (wait_left > 0)
            begin
                res_ready <= 1'b0;
                wait_left--;
            end
            else
            begin
                res_ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // watchdog: too long without any transaction ends the run
    // ------------------------------------------------------------------

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((ev_valid && ev_ready) || (res_valid && res_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("%0t ns: timeout, no transaction for %0d cycles", $time, quiet);
        $display("RESULT: ERROR");
        $finish;
    end

    // ------------------------------------------------------------------
    // sender helpers, all entered and left at a falling edge
    // ------------------------------------------------------------------

    function automatic pmc_pkg::pmc_in_t ev_item(input logic f, input logic [7:0] d,
                                                 input logic k, input logic [1:0] a,
                                                 input logic ab, input logic [31:0] av,
                                                 input logic [31:0] rv,
                                                 input logic [pmc_pkg::TIME_BITS-1:0] t,
                                                 input logic s);
        pmc_pkg::pmc_in_t it;
        it.func         = f;
        it.src_dev      = d;
        it.kind         = k;
        it.axis         = a;
        it.is_absolute  = ab;
        it.abs_value    = av;
        it.rel_value    = rv;
        it.timestamp_us = t;
        it.sink_active  = s;
        return it;
    endfunction

    function automatic plan_row_t row_pred(input pmc_pkg::pmc_in_t it);
        plan_row_t r;
        r = '0;
        r.item = it;
        return r;
    endfunction

    function automatic plan_row_t row_fixed(input pmc_pkg::pmc_in_t it, input logic [1:0] n,
                                            input pmc_pkg::pmc_out_t o0,
                                            input pmc_pkg::pmc_out_t o1,
                                            input pmc_pkg::pmc_out_t o2);
        plan_row_t r;
        r.item    = it;
        r.fixed   = 1'b1;
        r.n_fixed = n;
        r.outs    = {o2, o1, o0};
        return r;
    endfunction

    // offer one transaction after a random gap while idling is on, return once it is taken
    task automatic push_event(input pmc_pkg::pmc_in_t it);
        int gap;
        gap = idle_on ? $urandom_range(0, IDLE_MAX) : 0;
        if (gap > 0)
        begin
            ev_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        ev_valid <= 1'b1;
        ev_data  <= it;
        do
            @(posedge clk);
        while (!ev_ready);
        @(negedge clk);
    endtask

    // stop offering, wait for every owed delivery, then let the pipe go quiet
    task automatic settle_out();
        ev_valid <= 1'b0;
        while (due_q.size() != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic write_window(input logic [pmc_pkg::WIN_W-1:0] v);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        m_window   = v;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    // mostly small deltas, some full range and some close to the rails
    function automatic logic [31:0] pick_delta();
        int r;
        r = $urandom_range(0, 9);
        if (r < 5)
            return 32'($urandom_range(0, 200)) - 32'd100;
        if (r < 8)
            return $urandom;
        if (r < 9)
            return 32'h7fff_ff00 + 32'($urandom_range(0, 255));
        return S32_MIN + 32'($urandom_range(0, 255));
    endfunction

    // motion runs from a current device, with flushes, pass events,
    // device changes and time jumps mixed in
    task automatic gen_item(output pmc_pkg::pmc_in_t it);
        int sel;
        int r;
        int w;
        w   = m_window;
        sel = $urandom_range(0, 99);
        r   = $urandom_range(0, 9);
        if (r < 6)
            ts_now = ts_now + pmc_pkg::TIME_BITS'($urandom_range(0, w / 3 + 1));
        else if (r < 9)
            ts_now = ts_now + pmc_pkg::TIME_BITS'($urandom_range(w / 2, w + 2));
        else
            ts_now = {8'($urandom), 32'($urandom)};
        if ($urandom_range(0, 11) == 0)
            cur_dev = $urandom_range(0, 1) ? 8'($urandom) : 8'($urandom_range(0, 3));
        it.func         = pmc_pkg::FUNC_EVENT;
        it.src_dev      = cur_dev;
        it.kind         = pmc_pkg::KIND_MOTION;
        it.axis         = $urandom_range(0, 1) ? pmc_pkg::AXIS_Y : pmc_pkg::AXIS_X;
        it.is_absolute  = ($urandom_range(0, 3) == 0);
        it.abs_value    = $urandom;
        it.rel_value    = pick_delta();
        it.timestamp_us = ts_now;
        it.sink_active  = ($urandom_range(0, 7) != 0);
        if (sel < 10)
        begin
            // end of dispatch, other fields are noise
            it.func        = pmc_pkg::FUNC_FLUSH;
            it.src_dev     = 8'($urandom);
            it.kind        = 1'($urandom);
            it.axis        = 2'($urandom);
        end
        else if (sel < 20)
        begin
            it.src_dev = 8'($urandom);
            if ($urandom_range(0, 1))
            begin
                it.kind = pmc_pkg::KIND_OTHER;
                it.axis = 2'($urandom);
            end
            else
            begin
                it.axis = $urandom_range(0, 1) ? AXIS_SPARE : AXIS_OTHER;
            end
        end
        else if (sel < 25)
        begin
            // stray motion from some other device
            it.src_dev = 8'($urandom);
        end
    endtask

    // ------------------------------------------------------------------
    // directed table
    // ------------------------------------------------------------------

    task automatic load_plan();
        // flush straight after reset, nothing pending
        plan.push_back(row_fixed(ev_item(pmc_pkg::FUNC_FLUSH, 8'h00, pmc_pkg::KIND_MOTION,
            pmc_pkg::AXIS_X, REL, 32'd0, 32'd0, 40'd0, SINK_ON), 2'd0, '0, '0, '0));
        // pass event with extreme fields
        plan.push_back(row_fixed(ev_item(pmc_pkg::FUNC_EVENT, 8'hff, pmc_pkg::KIND_OTHER,
            AXIS_SPARE, ABS, S32_MIN, S32_MAX, 40'd0, SINK_ON), 2'd1,
            mk_out(8'hff, pmc_pkg::KIND_OTHER, AXIS_SPARE, ABS, S32_MIN, S32_MAX,
                   1'b0, 1'b1),
            '0, '0));
        // relative sum saturating high, then an absolute Y
        plan.push_back(row_fixed(ev_item(pmc_pkg::FUNC_EVENT, 8'h01, pmc_pkg::KIND_MOTION,
            pmc_pkg::AXIS_X, REL, 32'd0, 32'd5, 40'd100, SINK_ON), 2'd0, '0, '0, '0));
        plan.push_back(row_fixed(ev_item(pmc_pkg::FUNC_EVENT, 8'h01, pmc_pkg::KIND_MOTION,
            pmc_pkg::AXIS_X, REL, 32'd0, S32_MAX, 40'd200, SINK_ON), 2'd0, '0, '0, '0));
        plan.push_back(row_fixed(ev_item(pmc_pkg::FUNC_EVENT, 8'h01, pmc_pkg::KIND_MOTION,
            pmc_pkg::AXIS_Y, ABS, 32'd1234, 32'd7, 40'd300, SINK_ON), 2'd0, '0, '0, '0));
        plan.push_back(row_fixed(ev_item(pmc_pkg::FUNC_FLUSH, 8'h00, pmc_pkg::KIND_MOTION,
            pmc_pkg::AXIS_X, REL, 32'd0, 32'd0, 40'd0, SINK_ON), 2'd2,
            mk_out(8'h01, pmc_pkg::KIND_MOTION, pmc_pkg::AXIS_X, REL, 32'd0, S32_MAX,
                   1'b1, 1'b0),
            mk_out(8'h01, pmc_pkg::KIND_MOTION, pmc_pkg::AXIS_Y, ABS, 32'd1234, 32'd7,
                   1'b0, 1'b1), '0));
        // saturating low, then a motion event on another axis passes through
        plan.push_back(row_fixed(ev_item(pmc_pkg::FUNC_EVENT, 8'h02, pmc_pkg::KIND_MOTION,
            pmc_pkg::AXIS_X, REL, 32'd0, S32_MIN, 40'd400, SINK_ON), 2'd0, '0, '0, '0));
        plan.push_back(row_fixed(ev_item(pmc_pkg::FUNC_EVENT, 8'h02, pmc_pkg::KIND_MOTION,
            pmc_pkg::AXIS_X, REL, 32'd0, 32'hffff_ffff, 40'd500, SINK_ON), 2'd0,
            '0, '0, '0));
        plan.push_back(row_pred(ev_item(pmc_pkg::FUNC_EVENT, 8'h02, pmc_pkg::KIND_MOTION,
            AXIS_OTHER, REL, 32'd11, 32'd22, 40'd600, SINK_ON)));
        // relative after absolute turns into a relative event
        plan.push_back(row_fixed(ev_item(pmc_pkg::FUNC_EVENT, 8'h03, pmc_pkg::KIND_MOTION,
            pmc_pkg::AXIS_X, ABS, 32'd77, 32'd3, 40'd1000, SINK_ON), 2'd0, '0, '0, '0));
        plan.push_back(row_fixed(ev_item(pmc_pkg::FUNC_EVENT, 8'h03, pmc_pkg::KIND_MOTION,
            pmc_pkg::AXIS_X, REL, 32'd0, 32'd10, 40'd1100, SINK_ON), 2'd0, '0, '0, '0));
        // device change flushes
        plan.push_back(row_pred(ev_item(pmc_pkg::FUNC_EVENT, 8'h04, pmc_pkg::KIND_MOTION,
            pmc_pkg::AXIS_Y, REL, 32'd0, 32'd4, 40'd1200, SINK_ON)));
        // window boundary: exactly the window holds, one more flushes
        plan.push_back(row_pred(ev_item(pmc_pkg::FUNC_EVENT, 8'h04, pmc_pkg::KIND_MOTION,
            pmc_pkg::AXIS_X, REL, 32'd0, 32'd1, 40'd11200, SINK_ON)));
        plan.push_back(row_pred(ev_item(pmc_pkg::FUNC_EVENT, 8'h04, pmc_pkg::KIND_MOTION,
            pmc_pkg::AXIS_Y, REL, 32'd0, 32'd2, 40'd11201, SINK_ON)));
        // timestamp going backwards
        plan.push_back(row_pred(ev_item(pmc_pkg::FUNC_EVENT, 8'h04, pmc_pkg::KIND_MOTION,
            pmc_pkg::AXIS_X, REL, 32'd0, 32'd9, 40'd5, SINK_ON)));
        // inactive sink drops both the flush and the pass event
        plan.push_back(row_fixed(ev_item(pmc_pkg::FUNC_EVENT, 8'h04, pmc_pkg::KIND_OTHER,
            pmc_pkg::AXIS_X, REL, 32'd1, 32'd1, 40'd6, SINK_OFF), 2'd0, '0, '0, '0));
        // window across the timestamp wrap, absolute replaces absolute
        plan.push_back(row_fixed(ev_item(pmc_pkg::FUNC_EVENT, 8'hff, pmc_pkg::KIND_MOTION,
            pmc_pkg::AXIS_X, ABS, S32_MAX, 32'd0, {pmc_pkg::TIME_BITS{1'b1}}, SINK_ON),
            2'd0, '0, '0, '0));
        plan.push_back(row_fixed(ev_item(pmc_pkg::FUNC_EVENT, 8'hff, pmc_pkg::KIND_MOTION,
            pmc_pkg::AXIS_X, ABS, S32_MIN, 32'd1, 40'd0, SINK_ON), 2'd0, '0, '0, '0));
        plan.push_back(row_fixed(ev_item(pmc_pkg::FUNC_EVENT, 8'hff, pmc_pkg::KIND_MOTION,
            pmc_pkg::AXIS_Y, REL, 32'd0, S32_MIN, 40'd10, SINK_ON), 2'd0, '0, '0, '0));
        // inactive flush clears, the next flush has nothing left
        plan.push_back(row_fixed(ev_item(pmc_pkg::FUNC_FLUSH, 8'hff, pmc_pkg::KIND_OTHER,
            AXIS_SPARE, ABS, S32_MAX, S32_MAX, {pmc_pkg::TIME_BITS{1'b1}}, SINK_OFF),
            2'd0, '0, '0, '0));
        plan.push_back(row_fixed(ev_item(pmc_pkg::FUNC_FLUSH, 8'h00, pmc_pkg::KIND_MOTION,
            pmc_pkg::AXIS_X, REL, 32'd0, 32'd0, 40'd0, SINK_ON), 2'd0, '0, '0, '0));
        // both axes pending ahead of a pass event: three deliveries
        plan.push_back(row_pred(ev_item(pmc_pkg::FUNC_EVENT, 8'h00, pmc_pkg::KIND_MOTION,
            pmc_pkg::AXIS_X, REL, 32'd0, 32'd1, 40'd20, SINK_ON)));
        plan.push_back(row_pred(ev_item(pmc_pkg::FUNC_EVENT, 8'h00, pmc_pkg::KIND_MOTION,
            pmc_pkg::AXIS_Y, REL, 32'd0, 32'd1, 40'd30, SINK_ON)));
        plan.push_back(row_pred(ev_item(pmc_pkg::FUNC_EVENT, 8'h00, pmc_pkg::KIND_OTHER,
            pmc_pkg::AXIS_X, ABS, 32'd5, 32'd6, 40'd40, SINK_ON)));
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------

    initial
    begin : stim
        pmc_pkg::pmc_in_t          it;
        logic [pmc_pkg::WIN_W-1:0] win;
        logic                      idle_save;

        repeat (3) @(negedge clk);
        rst_n <= 1'b1;

        // directed part at the reset window
        load_plan();
        foreach (plan[i])
        begin
            cur_fixed = plan[i].fixed;
            cur_n     = plan[i].n_fixed;
            cur_outs  = plan[i].outs;
            push_event(plan[i].item);
        end
        cur_fixed = 1'b0;

        // random phases: zero window, top of range, 1000000, then others
        for (int p = 0; p < 6; p++)
        begin
            settle_out();
            case (p)
                0:       win = '0;
                1:       win = {pmc_pkg::WIN_W{1'b1}};
                2:       win = pmc_pkg::WIN_W'(1000000);
                3:       win = pmc_pkg::WIN_W'(37);
                4:       win = pmc_pkg::WIN_W'(300);
                default: win = pmc_pkg::WIN_W'($urandom_range(0, 2000));
            endcase
            write_window(win);

            if (p == 2)
            begin
                // receiver holds off while pass events keep coming back to back
                long_hold_req = 1'b1;
                idle_save     = idle_on;
                idle_on       = 1'b0;
                repeat (10)
                begin
                    it = ev_item(pmc_pkg::FUNC_EVENT, 8'($urandom), pmc_pkg::KIND_OTHER,
                                 2'($urandom), 1'($urandom), $urandom, $urandom,
                                 ts_now, SINK_ON);
                    push_event(it);
                end
                idle_on = idle_save;
            end

            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                // stretches with and without idling
                if (k % 15 == 0)
                    idle_on = ($urandom_range(0, 3) != 0);
                gen_item(it);
                push_event(it);
            end
        end

        settle_out();
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
